### rtl/deq_pkg.sv
`timescale 1ns / 1ps
package deq_pkg;

   localparam int ELEM_W = 32;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_DISPLAY    = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [ELEM_W-1:0] value;
   } cell_ctl_type;

endpackage

### rtl/deq_cell.sv
`timescale 1ns / 1ps
module deq_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  deq_pkg::cell_ctl_type             ctl,
   input  logic signed [deq_pkg::ELEM_W-1:0] left_data,
   input  logic                              left_valid,
   input  logic signed [deq_pkg::ELEM_W-1:0] right_data,
   input  logic                              right_valid,
   input  logic signed [deq_pkg::ELEM_W-1:0] head_data,
   output logic signed [deq_pkg::ELEM_W-1:0] data,
   output logic                              valid,
   output logic signed [deq_pkg::ELEM_W-1:0] tap
);
   import deq_pkg::*;

   logic signed [ELEM_W-1:0] data_ff;
   logic signed [ELEM_W-1:0] data_in;
   logic                     valid_ff;
   logic                     valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      case (ctl.op)
         OP_HOLD: begin
         end
         OP_PUSH_FRONT: begin
            data_in  = left_data;
            valid_in = left_valid;
         end
         OP_PUSH_BACK: begin
            if (!valid_ff && left_valid) begin
               data_in  = ctl.value;
               valid_in = 1'b1;
            end
         end
         OP_POP_FRONT: begin
            data_in  = right_data;
            valid_in = right_valid;
         end
         OP_POP_BACK: begin
            if (valid_ff && !right_valid) begin
               valid_in = 1'b0;
            end
         end
         OP_ROTATE: begin
            if (right_valid) begin
               data_in = right_data;
            end else if (valid_ff) begin
               data_in = head_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign valid = valid_ff;
   // back end of the chain drives the pop-back bus
   assign tap   = (valid_ff && !right_valid) ? data_ff : '0;

endmodule

### rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// Bounded deque of signed 32-bit values held in a row of DEPTH cells, cell 0 being
// the front. Push front, push back, pop front and pop back each give one result
// item; a push to a full deque is dropped with full status, a pop from an empty
// one reports empty. Display gives one item per stored element, front to back,
// each produced while the output register is free, by rotating the cell chain one
// step per item so that it ends where it began; no request is taken until the last
// display item has been registered. Display of an empty deque gives one item with
// empty status. Command codes 5 to 7 are taken and give no result. A result
// register sits on the output, so a new request is taken while the previous result
// is being handed over.
module double_ended_queue #(
   parameter int DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_cmd,
   input  logic signed [deq_pkg::ELEM_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [deq_pkg::ELEM_W-1:0] rsp_element,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_last
);
   import deq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SHOW = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        remain_ff, remain_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [ELEM_W-1:0] rsp_element_ff, rsp_element_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic                    rsp_last_ff, rsp_last_in;

   cell_ctl_type             ctl;
   logic signed [ELEM_W-1:0] cell_data [DEPTH];
   logic signed [ELEM_W-1:0] cell_tap  [DEPTH];
   logic [DEPTH-1:0]         valid_vec;
   logic signed [ELEM_W-1:0] back_data;
   logic                     out_free;
   logic                     accept;
   logic                     is_full;
   logic                     is_empty;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign is_full   = (count_ff == CNT_FULL);
   assign is_empty  = (count_ff == '0);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [ELEM_W-1:0] l_data, r_data;
      logic                     l_valid, r_valid;
      if (i == 0) begin : g_first
         assign l_data  = ctl.value;
         assign l_valid = 1'b1;
      end else begin : g_mid
         assign l_data  = cell_data[i-1];
         assign l_valid = valid_vec[i-1];
      end
      if (i == DEPTH - 1) begin : g_end
         assign r_data  = '0;
         assign r_valid = 1'b0;
      end else begin : g_inner
         assign r_data  = cell_data[i+1];
         assign r_valid = valid_vec[i+1];
      end
      deq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_data   (l_data),
         .left_valid  (l_valid),
         .right_data  (r_data),
         .right_valid (r_valid),
         .head_data   (cell_data[0]),
         .data        (cell_data[i]),
         .valid       (valid_vec[i]),
         .tap         (cell_tap[i])
      );
   end

   always_comb begin
      back_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_data = back_data | cell_tap[i];
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      remain_in      = remain_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_element_in = rsp_element_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      ctl.op         = OP_HOLD;
      ctl.value      = req_value;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_element_in = '0;
               rsp_status_in  = STATUS_OK;
               rsp_last_in    = 1'b1;
               case (req_cmd)
                  CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ctl.op   = (req_cmd == CMD_PUSH_FRONT) ? OP_PUSH_FRONT
                                                               : OP_PUSH_BACK;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else if (req_cmd == CMD_POP_FRONT) begin
                        ctl.op         = OP_POP_FRONT;
                        rsp_element_in = cell_data[0];
                        count_in       = count_ff - 1'b1;
                     end else begin
                        ctl.op         = OP_POP_BACK;
                        rsp_element_in = back_data;
                        count_in       = count_ff - 1'b1;
                     end
                  end
                  CMD_DISPLAY: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        state_in  = ST_SHOW;
                        remain_in = count_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SHOW: begin
            if (out_free) begin
               ctl.op         = OP_ROTATE;
               rsp_valid_in   = 1'b1;
               rsp_element_in = cell_data[0];
               rsp_status_in  = STATUS_OK;
               rsp_last_in    = (remain_ff == CNT_W'(1));
               remain_in      = remain_ff - 1'b1;
               if (remain_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_element_ff <= rsp_element_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_last    = rsp_last_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("element count beyond depth");

   a_count_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("occupied cells disagree with count");

   a_cells_packed: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & DEPTH'(valid_vec + 1'b1)) == '0)
      else $error("occupied cells not packed toward front");

   a_show_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHOW) |-> (req_stall && remain_ff != '0))
      else $error("display walk not blocking requests");

   a_show_steady: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHOW) |=> $stable(count_ff))
      else $error("count changed during display");
`endif

endmodule

### tb/sv/tb_double_ended_queue.sv
`timescale 1ns / 1ps
module tb_double_ended_queue;
   import deq_pkg::*;

   localparam int DEPTH = 32;
   localparam int MAX_WAIT = 14;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 40;
   localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
   localparam int UNUSED_CODES = 3;

   typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_type;

   typedef struct {
      logic signed [ELEM_W-1:0] element;
      status_type               status;
      logic                     last;
   } deq_item_type;

   class deque_tracker;
      logic signed [ELEM_W-1:0] ring [DEPTH];
      int                       front;
      int                       count;
      deq_item_type             awaited [$];
      int                       errors;

      function new();
         front = 0;
         count = 0;
         errors = 0;
      endfunction

      function void await_item(logic signed [ELEM_W-1:0] e, status_type s, logic l);
         deq_item_type it;
         it.element = e;
         it.status = s;
         it.last = l;
         awaited.push_back(it);
      endfunction

      function void note_command(logic [2:0] c, logic signed [ELEM_W-1:0] v);
         case (c)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
               if (count >= DEPTH) begin
                  await_item('0, STATUS_FULL, 1'b1);
               end else begin
                  if (c == CMD_PUSH_FRONT) begin
                     front = (front + DEPTH - 1) % DEPTH;
                     ring[front] = v;
                  end else begin
                     ring[(front + count) % DEPTH] = v;
                  end
                  count++;
                  await_item('0, STATUS_OK, 1'b1);
               end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
               if (count == 0) begin
                  await_item('0, STATUS_EMPTY, 1'b1);
               end else begin
                  if (c == CMD_POP_FRONT) begin
                     await_item(ring[front], STATUS_OK, 1'b1);
                     front = (front + 1) % DEPTH;
                  end else begin
                     await_item(ring[(front + count - 1) % DEPTH], STATUS_OK, 1'b1);
                  end
                  count--;
                  if (count == 0) front = 0;
               end
            end
            CMD_DISPLAY: begin
               if (count == 0) begin
                  await_item('0, STATUS_EMPTY, 1'b1);
               end else begin
                  for (int i = 0; i < count; i++)
                     await_item(ring[(front + i) % DEPTH], STATUS_OK, i == count - 1);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_item(logic signed [ELEM_W-1:0] e, logic [1:0] s, logic l);
         deq_item_type it;
         if (awaited.size() == 0) begin
            $error("unexpected item: element %0d status %0d last %0d", e, s, l);
            errors++;
            return;
         end
         it = awaited.pop_front();
         if (e !== it.element) begin
            $error("element: expected %0d actual %0d", it.element, e);
            errors++;
         end
         if (s !== it.status) begin
            $error("status: expected %0d actual %0d", it.status, s);
            errors++;
         end
         if (l !== it.last) begin
            $error("last: expected %0d actual %0d", it.last, l);
            errors++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [2:0]               req_cmd;
   logic signed [ELEM_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [ELEM_W-1:0] rsp_element;
   logic [1:0]               rsp_status;
   logic                     rsp_last;

   deque_tracker tracker = new();
   int           tx_max;
   int           rx_max;
   int           rx_hold;
   int           cycle_count;

   double_ended_queue #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_element(rsp_element),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL");
      $finish;
   end

   always @(negedge clock) begin
      rsp_stall <= (rx_hold > 0);
      if (rx_hold > 0) rx_hold--;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_item(rsp_element, rsp_status, rsp_last);
         rx_hold = $urandom_range(0, rx_max);
      end
   end

   task automatic send_item(input logic [2:0] c, input logic signed [ELEM_W-1:0] v);
      int gap;
      gap = $urandom_range(0, tx_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= c;
      req_value <= v;
      do @(posedge clock); while (req_stall);
      tracker.note_command(c, v);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   function automatic logic [2:0] pick_cmd(phase_type kind);
      int roll;
      roll = $urandom_range(0, 99);
      case (kind)
         PH_FILL: begin
            if (roll < 85) return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
            if (roll < 92) return CMD_DISPLAY;
            return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
         end
         PH_DRAIN: begin
            if (roll < 85) return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
            if (roll < 92) return CMD_DISPLAY;
            return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
         end
         default: begin
            if (roll < 5) return CMD_FIRST_UNUSED + 3'($urandom_range(0, UNUSED_CODES - 1));
            return 3'($urandom_range(CMD_PUSH_FRONT, CMD_DISPLAY));
         end
      endcase
   endfunction

   function automatic logic signed [ELEM_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      phase_type plan [4];
      int        plan_len [4];
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_PUSH_FRONT;
      req_value = '0;
      rsp_stall = 1'b0;
      rx_hold = 0;
      tx_max = 0;
      rx_max = 0;
      cycle_count = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty cases, extremes, unused codes, pop to empty
      tx_max = MAX_WAIT;
      rx_max = MAX_WAIT;
      send_item(CMD_POP_FRONT, pick_value());
      send_item(CMD_POP_BACK, pick_value());
      send_item(CMD_DISPLAY, pick_value());
      send_item(CMD_PUSH_FRONT, 32'sh8000_0000);
      send_item(CMD_PUSH_BACK, 32'sh7fff_ffff);
      send_item(CMD_PUSH_FRONT, -32'sd1);
      send_item(CMD_PUSH_BACK, 32'sd0);
      send_item(CMD_DISPLAY, 32'sd0);
      send_item(CMD_POP_FRONT, 32'sd0);
      send_item(CMD_POP_BACK, 32'sd0);
      send_item(CMD_DISPLAY, 32'sd0);
      for (int k = 0; k < UNUSED_CODES; k++)
         send_item(CMD_FIRST_UNUSED + 3'(k), $urandom());
      send_item(CMD_POP_BACK, 32'sd0);
      send_item(CMD_POP_FRONT, 32'sd0);
      send_item(CMD_POP_FRONT, 32'sd0);
      send_item(CMD_PUSH_BACK, 32'sh5555_5555);
      send_item(CMD_PUSH_FRONT, 32'shaaaa_aaaa);
      send_item(CMD_DISPLAY, 32'sd0);
      send_item(CMD_POP_BACK, 32'sd0);
      send_item(CMD_POP_BACK, 32'sd0);
      wait_drained();

      plan[0] = PH_FILL;  plan_len[0] = 42;
      plan[1] = PH_MIXED; plan_len[1] = 30;
      plan[2] = PH_DRAIN; plan_len[2] = 42;
      plan[3] = PH_FILL;  plan_len[3] = 40;
      for (int ph = 0; ph < 4; ph++) begin
         tx_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_WAIT;
         rx_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_WAIT;
         for (int n = 0; n < plan_len[ph]; n++)
            send_item(pick_cmd(plan[ph]), pick_value());
         if (ph % 2 == 0) wait_drained();
      end
      // deque left by the last fill phase listed end to end
      send_item(CMD_DISPLAY, 32'sd0);

      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
